@@ hdl/tdpt_pkg.sv @@
// ---------------------------------------------------------------------------
// tdpt_pkg
// shared types and constants for the trial division prime test
// ---------------------------------------------------------------------------
package tdpt_pkg;

  // width of the candidate field on the request port
  localparam int CANDIDATE_WIDTH = 32;

  // defaults for the top level parameters
  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // trial divisor sequence: 3, 5, 7, ...
  localparam int FIRST_DIVISOR = 3;
  localparam int DIVISOR_STEP  = 2;

  // class given to a request by the front end
  typedef enum logic [1:0] {
    CLS_COMPOSITE = 2'd0,
    CLS_PRIME     = 2'd1,
    CLS_TRIAL     = 2'd2
  } cls_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BACK_IDLE = 2'd0,
    BACK_DIV  = 2'd1,
    BACK_EVAL = 2'd2,
    BACK_DONE = 2'd3
  } back_state_t;

endpackage

@@ hdl/trial_division_prime_test_top.sv @@
// ---------------------------------------------------------------------------
// trial_division_prime_test_top
// primality test of one unsigned integer by odd trial division
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  in_      request    in_valid / in_ready   in_candidate   (32 bit unsigned)
//  out_     result     out_valid / out_ready out_prime_flag (1 bit)
//
//  timing: zero, one, two and even candidates are classified by the front end
//    and go straight to the done state; an odd candidate n runs the bit-serial
//    divider once per trial divisor, with odd divisors from 3 upward, until one
//    divides n or exceeds n / divisor
//  reset: rst_n clears the front stage, the queue pointers and the engine state
//  stalls: the queue lets requests keep arriving while the engine works; a held
//    result stalls the engine, and the front end stalls once the queue is full
//
// ---------------------------------------------------------------------------
module trial_division_prime_test_top #(
  parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = tdpt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] in_candidate,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_prime_flag
);
  import tdpt_pkg::*;

  // front end to queue
  logic                    push_valid;
  logic                    push_ready;
  cls_t                    push_cls;
  logic [NUMBER_WIDTH-1:0] push_num;

  // queue to back end
  logic                    pop_valid;
  logic                    pop_ready;
  cls_t                    pop_cls;
  logic [NUMBER_WIDTH-1:0] pop_num;

  // front end: trims the candidate and sorts out the trivial cases
  tdpt_front #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_candidate (in_candidate),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cls     (push_cls),
    .push_num     (push_num)
  );

  // decouples acceptance from the long division runs
  tdpt_queue #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cls   (push_cls),
    .push_num   (push_num),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cls    (pop_cls),
    .pop_num    (pop_num)
  );

  // back end: odd divisors 3, 5, 7, ... until one divides n or exceeds n / divisor
  tdpt_back #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_cls        (pop_cls),
    .pop_num        (pop_num),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prime_flag (out_prime_flag)
  );

endmodule

@@ hdl/tdpt_front.sv @@
// ---------------------------------------------------------------------------
// tdpt_front
// accepts requests, trims the candidate and classifies it
// ---------------------------------------------------------------------------
module tdpt_front #(
  parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] in_candidate,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output tdpt_pkg::cls_t                       push_cls,
  output logic [NUMBER_WIDTH-1:0]              push_num
);
  import tdpt_pkg::*;

  localparam int KeepW = (NUMBER_WIDTH < CANDIDATE_WIDTH) ? NUMBER_WIDTH : CANDIDATE_WIDTH;

  logic                    valid_r;
  logic                    valid_nxt;
  cls_t                    cls_r;
  cls_t                    cls_nxt;
  logic [NUMBER_WIDTH-1:0] num_r;
  logic [NUMBER_WIDTH-1:0] num_nxt;
  logic                    take;

  // bits at and above NUMBER_WIDTH are dropped
  assign num_nxt = NUMBER_WIDTH'(in_candidate[KeepW-1:0]);

  always_comb begin
    priority if (num_nxt[NUMBER_WIDTH-1:1] == '0) begin
      cls_nxt = CLS_COMPOSITE;          // zero and one
    end else if (num_nxt == NUMBER_WIDTH'(2)) begin
      cls_nxt = CLS_PRIME;
    end else if (!num_nxt[0]) begin
      cls_nxt = CLS_COMPOSITE;          // other even numbers
    end else begin
      cls_nxt = CLS_TRIAL;
    end
  end

  assign in_ready   = !valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign valid_nxt  = take || (valid_r && !push_ready);
  assign push_valid = valid_r;
  assign push_cls   = cls_r;
  assign push_num   = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r <= cls_nxt;
      num_r <= num_nxt;
    end
  end

endmodule

@@ hdl/tdpt_queue.sv @@
// ---------------------------------------------------------------------------
// tdpt_queue
// small first-in first-out queue between front end and back end
// ---------------------------------------------------------------------------
module tdpt_queue #(
  parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = tdpt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  tdpt_pkg::cls_t          push_cls,
  input  logic [NUMBER_WIDTH-1:0] push_num,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output tdpt_pkg::cls_t          pop_cls,
  output logic [NUMBER_WIDTH-1:0] pop_num
);
  import tdpt_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cls_t                    entry_cls_r [QUEUE_DEPTH];
  logic [NUMBER_WIDTH-1:0] entry_num_r [QUEUE_DEPTH];
  logic [PtrW-1:0]         wr_ptr_r;
  logic [PtrW-1:0]         wr_ptr_nxt;
  logic [PtrW-1:0]         rd_ptr_r;
  logic [PtrW-1:0]         rd_ptr_nxt;
  logic [CntW-1:0]         count_r;
  logic [CntW-1:0]         count_nxt;
  logic                    push;
  logic                    pop;

  assign push_ready = (count_r != CntW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cls    = entry_cls_r[rd_ptr_r];
  assign pop_num    = entry_num_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_cls_r[wr_ptr_r] <= push_cls;
      entry_num_r[wr_ptr_r] <= push_num;
    end
  end

endmodule

@@ hdl/tdpt_back.sv @@
// ---------------------------------------------------------------------------
// tdpt_back
// trial division engine: one restoring divider reused for each odd divisor
// ---------------------------------------------------------------------------
module tdpt_back #(
  parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  tdpt_pkg::cls_t          pop_cls,
  input  logic [NUMBER_WIDTH-1:0] pop_num,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_prime_flag
);
  import tdpt_pkg::*;

  localparam int W    = NUMBER_WIDTH;
  localparam int CntW = $clog2(W);

  back_state_t     state_r;
  back_state_t     state_nxt;
  logic [W-1:0]    n_r;
  logic [W-1:0]    n_nxt;
  logic [W-1:0]    d_r;
  logic [W-1:0]    d_nxt;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    rem_nxt;
  logic [W-1:0]    quo_r;
  logic [W-1:0]    quo_nxt;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  logic            res_r;
  logic            res_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_flag_r;
  logic            out_flag_nxt;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            fits;
  logic            out_free;

  // one quotient bit per cycle
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign fits  = (trial >= {1'b0, d_r});

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = (state_r == BACK_IDLE);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      BACK_IDLE: begin
        if (pop_valid) begin
          unique case (pop_cls)
            CLS_TRIAL: begin
              n_nxt     = pop_num;
              d_nxt     = W'(FIRST_DIVISOR);
              rem_nxt   = '0;
              quo_nxt   = pop_num;
              cnt_nxt   = CntW'(W - 1);
              state_nxt = BACK_DIV;
            end
            CLS_PRIME: begin
              res_nxt   = 1'b1;
              state_nxt = BACK_DONE;
            end
            default: begin
              res_nxt   = 1'b0;
              state_nxt = BACK_DONE;
            end
          endcase
        end
      end
      BACK_DIV: begin
        rem_nxt = fits ? diff[W-1:0] : trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], fits};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = BACK_EVAL;
        end
      end
      BACK_EVAL: begin
        // divisor past n / divisor: no divisor left to try
        priority if (d_r > quo_r) begin
          res_nxt   = 1'b1;
          state_nxt = BACK_DONE;
        end else if (rem_r == '0) begin
          res_nxt   = 1'b0;
          state_nxt = BACK_DONE;
        end else begin
          d_nxt     = d_r + W'(DIVISOR_STEP);
          rem_nxt   = '0;
          quo_nxt   = n_r;
          cnt_nxt   = CntW'(W - 1);
          state_nxt = BACK_DIV;
        end
      end
      BACK_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = res_r;
          state_nxt     = BACK_IDLE;
        end
      end
      default: begin
        state_nxt = BACK_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_prime_flag = out_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BACK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_flag_r <= out_flag_nxt;
  end

  // partial remainder stays below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BACK_DIV) |-> (rem_r < d_r))
    else $error("partial remainder not below divisor");

  // trial divisors are odd and at least three
  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BACK_DIV || state_r == BACK_EVAL) |-> (d_r[0] && d_r >= W'(FIRST_DIVISOR)))
    else $error("trial divisor even or below three");

  // a result only appears out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == BACK_DONE))
    else $error("result issued outside done state");

endmodule
